// ===== rtl/waveguide_mesh_3d_step_core_macros.svh =====
// Assertion macros for the mesh step core
`ifndef WAVEGUIDE_MESH_3D_STEP_CORE_MACROS_SVH
`define WAVEGUIDE_MESH_3D_STEP_CORE_MACROS_SVH
// check that a condition implies a consequence on the same edge
`define WGM_ASSERT_IMP(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error(msg);
// check that a condition implies a consequence on the next edge
`define WGM_ASSERT_NEXT(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error(msg);
`endif

// ===== rtl/wgm3d_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package wgm3d_pkg;
   localparam int MaxSide = 16;
   localparam int CoordBits = 4;
   localparam int AddrBits = 3 * CoordBits;
   localparam int Depth = MaxSide * MaxSide * MaxSide;
   localparam int ValueBits = 32;
   localparam int SizeBits = 5;

   localparam logic [1:0] OP_WRITE_CUR = 2'd0;
   localparam logic [1:0] OP_WRITE_PRV = 2'd1;
   localparam logic [1:0] OP_READ_CUR = 2'd2;
   localparam logic [1:0] OP_STEP = 2'd3;

   localparam logic [1:0] REG_REFLECTION = 2'd0;
   localparam logic [1:0] REG_SIZE_X = 2'd1;
   localparam logic [1:0] REG_SIZE_Y = 2'd2;
   localparam logic [1:0] REG_SIZE_Z = 2'd3;

   typedef logic [AddrBits-1:0] addr_type;
   typedef logic signed [ValueBits-1:0] value_type;

   // clamp a configured extent to [3, MaxSide] and return it as top index
   function automatic logic [CoordBits-1:0] last_index(input logic [SizeBits-1:0] s);
      logic [SizeBits-1:0] u;
      begin
         if (s < SizeBits'(3)) u = SizeBits'(3);
         else if (s > SizeBits'(MaxSide)) u = SizeBits'(MaxSide);
         else u = s;
         last_index = CoordBits'(u - SizeBits'(1));
      end
   endfunction

   function automatic addr_type node_addr(input logic [CoordBits-1:0] x,
                                          input logic [CoordBits-1:0] y,
                                          input logic [CoordBits-1:0] z);
      node_addr = {z, y, x};
   endfunction
endpackage
`default_nettype wire

// ===== rtl/wgm3d_field_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module wgm3d_field_ram (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire wgm3d_pkg::addr_type  wr_addr,
   input  wire wgm3d_pkg::value_type wr_data,
   input  wire wgm3d_pkg::addr_type  rd_addr,
   output wgm3d_pkg::value_type      rd_data
);
   import wgm3d_pkg::*;

   value_type mem [Depth];
   value_type rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

// ===== rtl/waveguide_mesh_3d_step_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Mesh step core: two 4096-node pressure fields (Q16.16) with a time step engine.
// Items: pulse start while busy is low with req_operation, coordinates and
// req_node_value. Operations: write current, write previous, read current, step.
// Each item yields one result: rsp_valid high one cycle with rsp_read_value
// (node on read, else 0) and rsp_saturated (any clip during a step, else 0).
// Configuration: csr_write_enable, csr_index, csr_write_data, written while idle.
// A write passes through S_DONE, a read through S_RD and S_RDW, before the strobe.
// Step: nodes are visited in order; an interior node makes six reads on the
// single read port of the current field and drains it, then one shared multiply,
// a correction and a write follow; a face node reads one neighbour, an edge or corner node none.
// The length of a full 16^3 step is set mainly by that one read port.
// busy stays high until the result strobe.
// Reset clears both fields in one pass over all 4096 nodes (one node a cycle in each
// bank); busy is high during it. Results cannot be held off by the receiver.
module waveguide_mesh_3d_step_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_operation,
   input  wire logic [3:0]  req_coord_x,
   input  wire logic [3:0]  req_coord_y,
   input  wire logic [3:0]  req_coord_z,
   input  wire logic signed [31:0] req_node_value,
   output logic             rsp_valid,
   output logic signed [31:0] rsp_read_value,
   output logic             rsp_saturated,
   input  wire logic        csr_write_enable,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_write_data
);
   import wgm3d_pkg::*;

   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_RD    = 4'd2;
   localparam logic [3:0] S_RDW   = 4'd3;
   localparam logic [3:0] S_NODE  = 4'd4;
   localparam logic [3:0] S_FETCH = 4'd5;
   localparam logic [3:0] S_ACC   = 4'd6;
   localparam logic [3:0] S_MUL   = 4'd7;
   localparam logic [3:0] S_DIV   = 4'd8;
   localparam logic [3:0] S_WB    = 4'd9;
   localparam logic [3:0] S_DONE  = 4'd10;

   logic [3:0] state_ff, state_in;
   logic signed [15:0] refl_ff;
   logic [SizeBits-1:0] sx_ff, sy_ff, sz_ff;
   logic bank_ff, bank_in;
   logic [1:0] op_ff;
   logic [CoordBits-1:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic [CoordBits-1:0] lx, ly, lz;
   value_type wv_ff;
   logic [2:0] tap_ff, tap_in;     // neighbor fetch counter
   logic [2:0] ntap_ff, ntap_in;   // taps needed (0,1 or 6)
   logic signed [34:0] acc_ff, acc_in;
   logic signed [66:0] prod_ff, prod_in;
   logic signed [34:0] tq_ff, tq_in;
   logic sat_ff, sat_in;
   logic rsp_v_ff, rsp_v_in;
   value_type rsp_d_ff, rsp_d_in;
   logic rsp_s_ff, rsp_s_in;
   addr_type clr_ff, clr_in;
   logic rv_ff;                    // marks that read data is valid this cycle

   // field banks
   logic wa_en, wb_en;
   addr_type wr_addr, ra_addr, rb_addr;
   value_type wr_data, ra_data, rb_data;

   wgm3d_field_ram u_ram_a (
      .clock(clock), .wr_en(wa_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(ra_addr), .rd_data(ra_data)
   );
   wgm3d_field_ram u_ram_b (
      .clock(clock), .wr_en(wb_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rb_addr), .rd_data(rb_data)
   );

   assign lx = last_index(sx_ff);
   assign ly = last_index(sy_ff);
   assign lz = last_index(sz_ff);

   // node classification
   logic bx, by, bz, inside_req;
   logic [1:0] faces;
   assign bx = (x_ff == '0) || (x_ff == lx);
   assign by = (y_ff == '0) || (y_ff == ly);
   assign bz = (z_ff == '0) || (z_ff == lz);
   assign faces = 2'(bx) + 2'(by) + 2'(bz);
   assign inside_req = (req_coord_x <= lx) && (req_coord_y <= ly) && (req_coord_z <= lz);

   // neighbor address for tap index
   logic [CoordBits-1:0] nx, ny, nz;
   always_comb begin
      nx = x_ff; ny = y_ff; nz = z_ff;
      if (faces == 2'd1) begin
         if (bx) nx = (x_ff == '0) ? CoordBits'(1) : lx - CoordBits'(1);
         else if (by) ny = (y_ff == '0) ? CoordBits'(1) : ly - CoordBits'(1);
         else nz = (z_ff == '0) ? CoordBits'(1) : lz - CoordBits'(1);
      end else begin
         case (tap_ff)
            3'd0: nx = x_ff + CoordBits'(1);
            3'd1: nx = x_ff - CoordBits'(1);
            3'd2: ny = y_ff + CoordBits'(1);
            3'd3: ny = y_ff - CoordBits'(1);
            3'd4: nz = z_ff + CoordBits'(1);
            default: nz = z_ff - CoordBits'(1);
         endcase
      end
   end

   value_type cur_q, prv_q;
   assign cur_q = bank_ff ? rb_data : ra_data;
   assign prv_q = bank_ff ? ra_data : rb_data;

   // saturating subtract of previous value
   logic signed [35:0] diff;
   value_type diff_clip;
   logic diff_hit;
   assign diff = 36'(tq_ff) - 36'(wv_ff);
   always_comb begin
      if (diff > 36'sh07FFFFFFF) begin
         diff_clip = 32'sh7FFFFFFF; diff_hit = 1'b1;
      end else if (diff < -36'sh080000000) begin
         diff_clip = 32'sh80000000; diff_hit = 1'b1;
      end else begin
         diff_clip = diff[31:0]; diff_hit = 1'b0;
      end
   end

   // shared multiplier operand: gain times neighbor, or sum times 1/3
   logic signed [17:0] gain;
   assign gain = 18'sd16384 + 18'(refl_ff);
   logic [34:0] abs_acc;
   assign abs_acc = acc_ff[34] ? 35'(-acc_ff) : 35'(acc_ff);
   logic signed [35:0] mul_a;
   logic signed [31:0] mul_b;
   logic signed [67:0] mul_p;
   assign mul_a = (faces == 2'd0) ? $signed({1'b0, abs_acc}) : 36'(acc_ff);
   assign mul_b = (faces == 2'd0) ? 32'sd1431655766 : 32'(gain);
   assign mul_p = 68'(mul_a) * 68'(mul_b);

   // sequencer
   always_comb begin
      addr_type cur_a, prv_a;
      logic [35:0] q3;
      state_in = state_ff; bank_in = bank_ff;
      x_in = x_ff; y_in = y_ff; z_in = z_ff;
      tap_in = tap_ff; ntap_in = ntap_ff; acc_in = acc_ff; prod_in = prod_ff;
      tq_in = tq_ff; sat_in = sat_ff; clr_in = clr_ff;
      rsp_v_in = 1'b0; rsp_d_in = '0; rsp_s_in = 1'b0;
      wa_en = 1'b0; wb_en = 1'b0; wr_addr = node_addr(x_ff, y_ff, z_ff); wr_data = '0;
      cur_a = node_addr(nx, ny, nz); prv_a = node_addr(x_ff, y_ff, z_ff);
      q3 = '0;
      case (state_ff)
         S_CLEAR: begin
            wa_en = 1'b1; wb_en = 1'b1; wr_addr = clr_ff;
            clr_in = clr_ff + addr_type'(1);
            if (clr_ff == '1) state_in = S_IDLE;
         end
         S_IDLE: begin
            cur_a = node_addr(req_coord_x, req_coord_y, req_coord_z);
            if (start) begin
               x_in = req_coord_x; y_in = req_coord_y; z_in = req_coord_z;
               case (req_operation)
                  OP_WRITE_CUR, OP_WRITE_PRV: begin
                     if (inside_req) begin
                        wr_addr = node_addr(req_coord_x, req_coord_y, req_coord_z);
                        wr_data = req_node_value;
                        if ((req_operation == OP_WRITE_CUR) ^ bank_ff) wa_en = 1'b1;
                        else wb_en = 1'b1;
                     end
                     state_in = S_DONE;
                  end
                  OP_READ_CUR: state_in = S_RD;
                  default: begin
                     x_in = '0; y_in = '0; z_in = '0; sat_in = 1'b0;
                     state_in = S_NODE;
                  end
               endcase
            end
         end
         S_RD: begin
            // hold the read address on the requested node
            cur_a = node_addr(x_ff, y_ff, z_ff);
            state_in = S_RDW;
         end
         S_RDW: begin
            rsp_v_in = 1'b1;
            rsp_d_in = ((x_ff <= lx) && (y_ff <= ly) && (z_ff <= lz)) ? cur_q : '0;
            state_in = S_IDLE;
         end
         S_NODE: begin
            // start neighbor fetch; previous value read rides on the other bank
            tap_in = '0; acc_in = '0;
            ntap_in = (faces == 2'd0) ? 3'd6 : (faces == 2'd1) ? 3'd1 : 3'd0;
            state_in = S_FETCH;
         end
         S_FETCH: begin
            // one current-field read per cycle; its data is registered and arrives in the next cycle
            if (rv_ff) acc_in = acc_ff + 35'(cur_q);
            if (tap_ff < ntap_ff) tap_in = tap_ff + 3'd1;
            else if (!rv_ff) state_in = S_ACC;
            if (tap_ff >= ntap_ff) cur_a = prv_a;
         end
         S_ACC: begin
            // previous value is valid now (read of own address)
            if (faces <= 2'd1) prod_in = mul_p[66:0];
            else prod_in = '0;
            state_in = S_MUL;
         end
         S_MUL: begin
            if (faces == 2'd0) begin
               q3 = prod_ff[67-1-1:32] > 0 ? 36'(prod_ff >>> 32) : '0;
               // trim the reciprocal estimate, which may run up to two high
               if (q3 * 36'd3 > 36'(abs_acc) + 36'd3) q3 = q3 - 36'd2;
               else if (q3 * 36'd3 > 36'(abs_acc)) q3 = q3 - 36'd1;
               tq_in = acc_ff[34] ? -35'(q3) : 35'(q3);
            end else if (faces == 2'd1) begin
               tq_in = prod_ff[66] ? 35'(-((-prod_ff) >>> 14)) : 35'(prod_ff >>> 14);
            end else tq_in = '0;
            state_in = S_DIV;
         end
         S_DIV: state_in = S_WB;
         S_WB: begin
            wr_data = diff_clip;
            if (bank_ff) wa_en = 1'b1; else wb_en = 1'b1;
            if (diff_hit) sat_in = 1'b1;
            state_in = S_NODE;
            if (x_ff == lx) begin
               x_in = '0;
               if (y_ff == ly) begin
                  y_in = '0;
                  if (z_ff == lz) begin
                     z_in = '0; bank_in = ~bank_ff; state_in = S_DONE;
                  end else z_in = z_ff + CoordBits'(1);
               end else y_in = y_ff + CoordBits'(1);
            end else x_in = x_ff + CoordBits'(1);
         end
         S_DONE: begin
            rsp_v_in = 1'b1; rsp_s_in = (op_ff == OP_STEP) & sat_ff;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
      if (bank_ff) begin rb_addr = cur_a; ra_addr = prv_a; end
      else begin ra_addr = cur_a; rb_addr = prv_a; end
   end

   // previous value captured once fetch ends
   value_type prv_hold_ff;
   always_ff @(posedge clock) begin
      if (state_ff == S_ACC) prv_hold_ff <= prv_q;
      if (state_ff == S_IDLE && start) wv_ff <= req_node_value;
      else if (state_ff == S_MUL) wv_ff <= prv_hold_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR; bank_ff <= 1'b0; clr_ff <= '0;
         refl_ff <= '0; sx_ff <= 5'd16; sy_ff <= 5'd16; sz_ff <= 5'd16;
         rsp_v_ff <= 1'b0; rv_ff <= 1'b0; sat_ff <= 1'b0; op_ff <= OP_WRITE_CUR;
      end else begin
         state_ff <= state_in; bank_ff <= bank_in; clr_ff <= clr_in;
         rsp_v_ff <= rsp_v_in; sat_ff <= sat_in;
         rv_ff <= (state_ff == S_FETCH) && (tap_ff < ntap_ff);
         if (state_ff == S_IDLE && start) op_ff <= req_operation;
         if (csr_write_enable) begin
            case (csr_index)
               REG_REFLECTION: refl_ff <= csr_write_data;
               REG_SIZE_X: sx_ff <= csr_write_data[SizeBits-1:0];
               REG_SIZE_Y: sy_ff <= csr_write_data[SizeBits-1:0];
               default: sz_ff <= csr_write_data[SizeBits-1:0];
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in; y_ff <= y_in; z_ff <= z_in;
      tap_ff <= tap_in; ntap_ff <= ntap_in; acc_ff <= acc_in;
      prod_ff <= prod_in; tq_ff <= tq_in;
      rsp_d_ff <= rsp_d_in; rsp_s_ff <= rsp_s_in;
   end

   assign busy = (state_ff != S_IDLE);
   assign rsp_valid = rsp_v_ff;
   assign rsp_read_value = rsp_d_ff;
   assign rsp_saturated = rsp_s_ff;

`include "waveguide_mesh_3d_step_core_macros.svh"
   `WGM_ASSERT_NEXT(a_one_result, clock, reset, (state_ff == S_IDLE) && start, busy, "accepted item did not raise busy")
   `WGM_ASSERT_IMP(a_rsp_idle, clock, reset, rsp_valid, state_ff == S_IDLE, "result strobe outside idle")
   `WGM_ASSERT_IMP(a_sat_step, clock, reset, rsp_valid && rsp_saturated, rsp_read_value == '0, "saturation flag on a read")
endmodule
`default_nettype wire
